>>> src/atp_pkg.sv
// Shared constants, types and the arctangent table for the accelerometer tilt block.
// Used by every module under src; depends on nothing else.
package atp_pkg;

  // Field widths of the stream payloads
  localparam int unsigned IN_W        = 16;
  localparam int unsigned ROLL_W      = 17;
  localparam int unsigned PITCH_W     = 16;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // Parameter defaults
  localparam int unsigned DEF_ANGLE_FRAC_BITS = 8;
  localparam int unsigned DEF_CORDIC_STEPS    = 16;

  // Operands of the arctangent units and the angle in Q30 radians
  localparam int unsigned OPND_W  = 2 * IN_W;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned ATAN_W  = 31;
  localparam int unsigned ATAN_TABLE_LEN = 24;
  localparam logic [ANGLE_W-1:0] PI_Q30      = 32'd3373259426;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 32'd1686629713;

  // Normalisation: the larger operand ends with its top bit at NORM_W-1
  localparam int unsigned NORM_W     = 41;
  localparam int unsigned NORM_STEPS = 6;

  // CORDIC datapath widths
  localparam int unsigned CORDIC_W   = 45;
  localparam int unsigned CORDIC_Z_W = 33;

  // Square root: radicand is the sum of squares, taken as Q32
  localparam int unsigned SQRT_IN_W   = 2 * IN_W;
  localparam int unsigned SQRT_ROOT_W = 32;
  localparam int unsigned SQRT_REM_W  = 34;

  // Degree scaling: theta * 57295 * 2^F + 500 * 2^30, over 125 * 2^33
  localparam int unsigned     DEG_SCALE_W    = 16;
  localparam logic [15:0]     DEG_SCALE      = 16'd57295;
  localparam logic [63:0]     DEG_ROUND      = 64'd536870912000;
  localparam int unsigned     DEG_DIV_SHIFT  = 33;
  localparam logic [63:0]     DEG_DIV        = 64'd125;
  localparam int unsigned     DEG_DIV_LOG2   = 7;

  // Control that travels beside an angle
  typedef struct packed {
    logic valid;
    logic mirror;  // take pi minus the first-quadrant angle
    logic neg;     // negate the degree result
  } atp_ctl_t;

  // atan(2^-i) in Q30
  function automatic logic [ATAN_W-1:0] atan_q30(input int unsigned i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:       v = 31'd843314857;
      1:       v = 31'd497837829;
      2:       v = 31'd263043837;
      3:       v = 31'd133525159;
      4:       v = 31'd67021687;
      5:       v = 31'd33543516;
      6:       v = 31'd16775851;
      7:       v = 31'd8388437;
      8:       v = 31'd4194283;
      9:       v = 31'd2097149;
      10:      v = 31'd1048576;
      11:      v = 31'd524288;
      12:      v = 31'd262144;
      13:      v = 31'd131072;
      14:      v = 31'd65536;
      15:      v = 31'd32768;
      16:      v = 31'd16384;
      17:      v = 31'd8192;
      18:      v = 31'd4096;
      19:      v = 31'd2048;
      20:      v = 31'd1024;
      21:      v = 31'd512;
      22:      v = 31'd256;
      23:      v = 31'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/accel_tilt_angles.sv
// Pipeline: three front-end stages, 32 square-root stages (one root bit each), six
// normalising shifts, one stage per CORDIC step, a quadrant stage, three degree-scaling
// stages and the output buffer.
// Throughput: one sample per cycle while the output buffer has a free entry; the
// two-entry output buffer keeps accepting while results wait. Reset: synchronous,
// active-low rst_n clears valid bits and the buffer.
module accel_tilt_angles #(
  parameter int unsigned ANGLE_FRAC_BITS = atp_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned CORDIC_STEPS    = atp_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] accel_x_raw, [31:16] accel_y_raw, [47:32] accel_z_raw
  input  logic [atp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [16:0] roll_deg_q8, [32:17] pitch_deg_q8, [39:33] zero
  output logic [atp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import atp_pkg::*;

  typedef struct packed {
    logic x_neg;
    logic y_nonneg;
    logic z_neg;
  } sign_t;

  typedef struct packed {
    sign_t           sign;
    logic [IN_W-1:0] ax;
    logic [IN_W-1:0] ay;
    logic [IN_W-1:0] az;
  } side_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [ROLL_W-1:0]  roll;
  } result_t;

  localparam int unsigned SB_W = $bits(side_t);
  localparam int unsigned SQ_W = 2 * IN_W;
  localparam logic [1:0]  SKID_FULL = 2'd2;

  logic en;

  // Front end: magnitudes and signs
  logic [IN_W-1:0] raw_x, raw_y, raw_z;
  sign_t           sign_nxt;
  logic [IN_W-1:0] ax_nxt, ay_nxt, az_nxt;

  logic            s1_valid_r;
  sign_t           s1_sign_r;
  logic [IN_W-1:0] s1_ax_r, s1_ay_r, s1_az_r;

  logic            s2_valid_r;
  side_t           s2_side_r;
  logic [SQ_W-1:0] s2_sqy_r, s2_sqz_r;

  logic            s3_valid_r;
  side_t           s3_side_r;
  logic [SQ_W-1:0] s3_sum_r;

  always_comb begin
    raw_x             = in_tdata[IN_W-1:0];
    raw_y             = in_tdata[2*IN_W-1:IN_W];
    raw_z             = in_tdata[3*IN_W-1:2*IN_W];
    sign_nxt.x_neg    = raw_x[IN_W-1];
    sign_nxt.y_nonneg = !raw_y[IN_W-1];
    sign_nxt.z_neg    = raw_z[IN_W-1];
    ax_nxt = raw_x[IN_W-1] ? (IN_W'(0) - raw_x) : raw_x;
    ay_nxt = raw_y[IN_W-1] ? (IN_W'(0) - raw_y) : raw_y;
    az_nxt = raw_z[IN_W-1] ? (IN_W'(0) - raw_z) : raw_z;
  end

  // Advance front-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Capture, square, then sum the y and z squares
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign_r      <= sign_nxt;
      s1_ax_r        <= ax_nxt;
      s1_ay_r        <= ay_nxt;
      s1_az_r        <= az_nxt;
      s2_side_r.sign <= s1_sign_r;
      s2_side_r.ax   <= s1_ax_r;
      s2_side_r.ay   <= s1_ay_r;
      s2_side_r.az   <= s1_az_r;
      s2_sqy_r       <= SQ_W'(s1_ay_r) * SQ_W'(s1_ay_r);
      s2_sqz_r       <= SQ_W'(s1_az_r) * SQ_W'(s1_az_r);
      s3_side_r      <= s2_side_r;
      s3_sum_r       <= s2_sqy_r + s2_sqz_r;
    end
  end

  // Square root of the y-z sum of squares, carrying the roll operands alongside
  logic                   sq_valid;
  logic [SQRT_ROOT_W-1:0] sq_root;
  logic [SB_W-1:0]        sq_side;
  side_t                  sq_side_s;

  atp_sqrt #(
    .SB_W (SB_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .in_rad    (s3_sum_r),
    .in_side   (s3_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_side_s = sq_side;

  // Roll: atan2(|y|, |z|), mirrored for negative z, negated for non-negative y
  atp_ctl_t           roll_in_ctl, pitch_in_ctl;
  logic [OPND_W-1:0]  roll_a, roll_b, pitch_a, pitch_b;
  atp_ctl_t           roll_ang_ctl, pitch_ang_ctl;
  logic [ANGLE_W-1:0] roll_theta, pitch_theta;

  always_comb begin
    roll_in_ctl.valid   = sq_valid;
    roll_in_ctl.mirror  = sq_side_s.sign.z_neg;
    roll_in_ctl.neg     = sq_side_s.sign.y_nonneg;
    roll_a              = OPND_W'(sq_side_s.az);
    roll_b              = OPND_W'(sq_side_s.ay);
    pitch_in_ctl.valid  = sq_valid;
    pitch_in_ctl.mirror = 1'b0;
    pitch_in_ctl.neg    = sq_side_s.sign.x_neg;
    pitch_a             = sq_root;
    pitch_b             = {sq_side_s.ax, {IN_W{1'b0}}};
  end

  atp_atan #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_roll_atan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ctl    (roll_in_ctl),
    .in_a      (roll_a),
    .in_b      (roll_b),
    .out_ctl   (roll_ang_ctl),
    .out_theta (roll_theta)
  );

  // Pitch: atan2(|x|, r), negated for negative x
  atp_atan #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_pitch_atan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ctl    (pitch_in_ctl),
    .in_a      (pitch_a),
    .in_b      (pitch_b),
    .out_ctl   (pitch_ang_ctl),
    .out_theta (pitch_theta)
  );

  atp_ctl_t           roll_deg_ctl, pitch_deg_ctl;
  logic [ROLL_W-1:0]  roll_val;
  logic [PITCH_W-1:0] pitch_val;

  atp_deg #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .OUT_W           (ROLL_W)
  ) u_roll_deg (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (roll_ang_ctl),
    .in_theta (roll_theta),
    .out_ctl  (roll_deg_ctl),
    .out_val  (roll_val)
  );

  atp_deg #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .OUT_W           (PITCH_W)
  ) u_pitch_deg (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (pitch_ang_ctl),
    .in_theta (pitch_theta),
    .out_ctl  (pitch_deg_ctl),
    .out_val  (pitch_val)
  );

  // Output buffer: two entries; the pipeline holds only when both are occupied
  logic [1:0] skid_cnt_r, skid_cnt_nxt;
  logic       skid_wr_r, skid_rd_r;
  result_t    skid_data_r [2];
  logic       push, pop;
  result_t    res_nxt;

  assign en        = (skid_cnt_r != SKID_FULL);
  assign in_tready = en;

  always_comb begin
    push          = en && roll_deg_ctl.valid && pitch_deg_ctl.valid;
    pop           = out_tvalid && out_tready;
    skid_cnt_nxt  = skid_cnt_r + {1'b0, push} - {1'b0, pop};
    res_nxt.roll  = roll_val;
    res_nxt.pitch = pitch_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_cnt_r <= '0;
      skid_wr_r  <= 1'b0;
      skid_rd_r  <= 1'b0;
    end else begin
      skid_cnt_r <= skid_cnt_nxt;
      if (push) begin
        skid_wr_r <= !skid_wr_r;
      end
      if (pop) begin
        skid_rd_r <= !skid_rd_r;
      end
    end
  end

  // Write the finished request into the free entry
  always_ff @(posedge clk) begin
    if (push) begin
      skid_data_r[skid_wr_r] <= res_nxt;
    end
  end

  assign out_tvalid = (skid_cnt_r != 2'd0);
  assign out_tdata  = OUT_TDATA_W'(skid_data_r[skid_rd_r]);

endmodule

>>> src/atp_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage, with a side band.
// Depends on atp_pkg.
module atp_sqrt #(
  parameter int unsigned SB_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [atp_pkg::SQRT_IN_W-1:0]      in_rad,
  input  logic [SB_W-1:0]                    in_side,
  output logic                               out_valid,
  output logic [atp_pkg::SQRT_ROOT_W-1:0]    out_root,
  output logic [SB_W-1:0]                    out_side
);
  import atp_pkg::*;

  localparam int unsigned STEPS = SQRT_ROOT_W;

  logic                   valid_r [STEPS];
  logic [SQRT_IN_W-1:0]   rad_r   [STEPS];
  logic [SQRT_ROOT_W-1:0] root_r  [STEPS];
  logic [SQRT_REM_W-1:0]  rem_r   [STEPS];
  logic [SB_W-1:0]        side_r  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_stage
    logic                   src_valid;
    logic [SQRT_IN_W-1:0]   src_rad;
    logic [SQRT_ROOT_W-1:0] src_root;
    logic [SQRT_REM_W-1:0]  src_rem;
    logic [SB_W-1:0]        src_side;
    logic [1:0]             pair;
    logic [SQRT_REM_W+1:0]  cand;
    logic [SQRT_REM_W+1:0]  trial;
    logic [SQRT_REM_W+1:0]  diff;
    logic                   fit;
    logic [SQRT_REM_W-1:0]  rem_nxt;
    logic [SQRT_ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rad   = in_rad;
      assign src_root  = '0;
      assign src_rem   = '0;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_valid = valid_r[j-1];
      assign src_rad   = rad_r[j-1];
      assign src_root  = root_r[j-1];
      assign src_rem   = rem_r[j-1];
      assign src_side  = side_r[j-1];
    end

    // Radicand is scaled by 2^SQRT_IN_W, so the low pairs are zero
    if (2 * j < SQRT_IN_W) begin : g_pair
      assign pair = src_rad[SQRT_IN_W-1-2*j -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    // Try the next root bit: subtract (4 * root + 1) where it fits
    always_comb begin
      cand     = {src_rem, pair};
      trial    = (SQRT_REM_W+2)'({src_root, 2'b01});
      diff     = cand - trial;
      fit      = (cand >= trial);
      rem_nxt  = fit ? diff[SQRT_REM_W-1:0] : cand[SQRT_REM_W-1:0];
      root_nxt = {src_root[SQRT_ROOT_W-2:0], fit};
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (en) begin
        valid_r[j] <= src_valid;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= src_rad;
        root_r[j] <= root_nxt;
        rem_r[j]  <= rem_nxt;
        side_r[j] <= src_side;
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

>>> src/atp_atan.sv
// First-quadrant arctangent of b over a: normalising shifts, pipelined CORDIC
// vectoring, clamp, special cases and the half-turn mirror. Depends on atp_pkg.
module atp_atan #(
  parameter int unsigned CORDIC_STEPS = atp_pkg::DEF_CORDIC_STEPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  atp_pkg::atp_ctl_t             in_ctl,
  input  logic [atp_pkg::OPND_W-1:0]    in_a,
  input  logic [atp_pkg::OPND_W-1:0]    in_b,
  output atp_pkg::atp_ctl_t             out_ctl,
  output logic [atp_pkg::ANGLE_W-1:0]   out_theta
);
  import atp_pkg::*;

  typedef struct packed {
    atp_ctl_t ctl;
    logic     zero_a;
    logic     zero_b;
  } flag_t;

  localparam int unsigned LAST_N = NORM_STEPS - 1;
  localparam int unsigned LAST_C = CORDIC_STEPS - 1;

  flag_t                        nf_r [NORM_STEPS];
  logic [NORM_W-1:0]            na_r [NORM_STEPS];
  logic [NORM_W-1:0]            nb_r [NORM_STEPS];

  flag_t                        cf_r [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]   cx_r [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]   cy_r [CORDIC_STEPS];
  logic signed [CORDIC_Z_W-1:0] cz_r [CORDIC_STEPS];

  flag_t                        fin_f_r;
  logic [ANGLE_W-1:0]           fin_theta_r;

  // Normalise: shift both operands left by halving steps while the top stays clear
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int unsigned SH = 1 << (NORM_STEPS - 1 - k);
    flag_t             src_f;
    logic [NORM_W-1:0] src_a;
    logic [NORM_W-1:0] src_b;
    logic [NORM_W-1:0] ab;
    logic              room;

    if (k == 0) begin : g_first
      always_comb begin
        src_f.ctl    = in_ctl;
        src_f.zero_a = (in_a == '0);
        src_f.zero_b = (in_b == '0);
        src_a        = NORM_W'(in_a);
        src_b        = NORM_W'(in_b);
      end
    end else begin : g_next
      assign src_f = nf_r[k-1];
      assign src_a = na_r[k-1];
      assign src_b = nb_r[k-1];
    end

    assign ab   = src_a | src_b;
    assign room = (ab[NORM_W-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nf_r[k] <= '0;
      end else if (en) begin
        nf_r[k] <= src_f;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        na_r[k] <= room ? (src_a << SH) : src_a;
        nb_r[k] <= room ? (src_b << SH) : src_b;
      end
    end
  end

  // CORDIC vectoring: rotate y towards zero, accumulate the angle
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [CORDIC_Z_W-1:0] STEP_ANG = $signed(CORDIC_Z_W'(atan_q30(i)));
    flag_t                        src_f;
    logic signed [CORDIC_W-1:0]   src_x;
    logic signed [CORDIC_W-1:0]   src_y;
    logic signed [CORDIC_Z_W-1:0] src_z;
    logic signed [CORDIC_W-1:0]   dx;
    logic signed [CORDIC_W-1:0]   dy;

    if (i == 0) begin : g_first
      always_comb begin
        src_f = nf_r[LAST_N];
        src_x = $signed(CORDIC_W'(na_r[LAST_N]));
        src_y = $signed(CORDIC_W'(nb_r[LAST_N]));
        src_z = '0;
      end
    end else begin : g_next
      assign src_f = cf_r[i-1];
      assign src_x = cx_r[i-1];
      assign src_y = cy_r[i-1];
      assign src_z = cz_r[i-1];
    end

    assign dx = src_y >>> i;
    assign dy = src_x >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cf_r[i] <= '0;
      end else if (en) begin
        cf_r[i] <= src_f;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!src_y[CORDIC_W-1]) begin
          cx_r[i] <= src_x + dx;
          cy_r[i] <= src_y - dy;
          cz_r[i] <= src_z + STEP_ANG;
        end else begin
          cx_r[i] <= src_x - dx;
          cy_r[i] <= src_y + dy;
          cz_r[i] <= src_z - STEP_ANG;
        end
      end
    end
  end

  // Clamp to the first quadrant, apply the zero-operand cases and the mirror
  logic signed [CORDIC_Z_W-1:0] zl;
  logic [ANGLE_W-1:0]           clamp;
  logic [ANGLE_W-1:0]           quad;
  logic [ANGLE_W-1:0]           theta_nxt;

  always_comb begin
    zl = cz_r[LAST_C];
    if (zl[CORDIC_Z_W-1]) begin
      clamp = '0;
    end else if (zl > $signed(CORDIC_Z_W'(HALF_PI_Q30))) begin
      clamp = HALF_PI_Q30;
    end else begin
      clamp = zl[ANGLE_W-1:0];
    end
    if (cf_r[LAST_C].zero_b) begin
      quad = '0;
    end else if (cf_r[LAST_C].zero_a) begin
      quad = HALF_PI_Q30;
    end else begin
      quad = clamp;
    end
    theta_nxt = cf_r[LAST_C].ctl.mirror ? (PI_Q30 - quad) : quad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_f_r <= '0;
    end else if (en) begin
      fin_f_r <= cf_r[LAST_C];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_theta_r <= theta_nxt;
    end
  end

  assign out_ctl   = fin_f_r.ctl;
  assign out_theta = fin_theta_r;

endmodule

>>> src/atp_deg.sv
// Three-stage scaling of a Q30 angle to rounded fixed-point degrees with sign,
// dividing by a constant through a reciprocal multiply. Depends on atp_pkg.
module atp_deg #(
  parameter int unsigned ANGLE_FRAC_BITS = atp_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned OUT_W           = atp_pkg::ROLL_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  atp_pkg::atp_ctl_t             in_ctl,
  input  logic [atp_pkg::ANGLE_W-1:0]   in_theta,
  output atp_pkg::atp_ctl_t             out_ctl,
  output logic [OUT_W-1:0]              out_val
);
  import atp_pkg::*;

  localparam int unsigned PROD_W  = ANGLE_W + DEG_SCALE_W;
  localparam int unsigned N_W     = PROD_W + ANGLE_FRAC_BITS + 1;
  localparam int unsigned QW      = N_W - DEG_DIV_SHIFT;
  localparam int unsigned K       = QW + DEG_DIV_LOG2;
  localparam int unsigned RECIP_W = K - DEG_DIV_LOG2 + 1;
  localparam int unsigned P2_W    = QW + RECIP_W;
  localparam int unsigned MMW     = P2_W - K;
  localparam int unsigned SW      = (MMW + 1 > OUT_W) ? MMW + 1 : OUT_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << K) + DEG_DIV - 64'd1) / DEG_DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  atp_ctl_t          c1_r, c2_r, c3_r;
  logic [PROD_W-1:0] prod_r;
  logic [P2_W-1:0]   p2_r;
  logic [OUT_W-1:0]  val_r;

  logic [N_W-1:0]    num;
  logic [QW-1:0]     quo;
  logic [MMW-1:0]    mag;
  logic [SW-1:0]     mag_s;
  logic [SW-1:0]     sgn;

  // Round half up, drop the power-of-two part, then divide by 125 via reciprocal
  always_comb begin
    num   = N_W'({prod_r, {ANGLE_FRAC_BITS{1'b0}}}) + N_W'(DEG_ROUND);
    quo   = num[N_W-1:DEG_DIV_SHIFT];
    mag   = p2_r[P2_W-1:K];
    mag_s = SW'(mag);
    sgn   = c2_r.neg ? (SW'(0) - mag_s) : mag_s;
  end

  // Advance the control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  // Advance the arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(in_theta) * PROD_W'(DEG_SCALE);
      p2_r   <= P2_W'(quo) * P2_W'(RECIP);
      val_r  <= sgn[OUT_W-1:0];
    end
  end

  assign out_ctl = c3_r;
  assign out_val = val_r;

endmodule

>>> bench/tilt_angle_checker.sv
`timescale 1ns / 100ps
// Checker for accel_tilt_angles: watches both stream channels and predicts roll and pitch.
// It compares every result with the oldest outstanding prediction.
// It depends on atp_pkg for field widths and the Q30 angle constants.
module tilt_angle_checker #(
  parameter int unsigned FRAC_BITS = atp_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned STEPS     = atp_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // [15:0] accel_x_raw, [31:16] accel_y_raw, [47:32] accel_z_raw
  input  logic [atp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [16:0] roll_deg_q8, [32:17] pitch_deg_q8, [39:33] zero
  input  logic [atp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                               mismatches,
  output int                               pending,
  output int                               compared,
  output int                               extremes
);

  import atp_pkg::*;

  localparam longint NORM_TOP = longint'(1) << 40;
  localparam longint unsigned MILLIDEG_PER_RAD = 64'd57295;

  // atan(2^-i) in Q30 radians
  localparam longint ARCTAN_STEP [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct packed {
    logic [ROLL_W-1:0]  roll;
    logic [PITCH_W-1:0] pitch;
  } tilt_angles_t;

  tilt_angles_t expected_angles [$];
  int fails_seen = 0;
  int results_seen = 0;
  int edge_cases_seen = 0;

  assign mismatches = fails_seen;
  assign pending    = expected_angles.size();
  assign compared   = results_seen;
  assign extremes   = edge_cases_seen;

  // Floor of the square root, one result bit per pass
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned acc;
    longint unsigned probe;
    acc = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= acc + probe) begin
        v = v - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe >>= 2;
    end
    return acc;
  endfunction

  // Vectoring CORDIC on non-negative operands: atan2(b, a) in Q30, clamped to [0, pi/2]
  function automatic longint unsigned quadrant_angle(input longint unsigned a,
                                                     input longint unsigned b);
    longint xa;
    longint yb;
    longint z;
    longint dx;
    longint dy;
    if (b == 0) return 0;
    if (a == 0) return longint'(HALF_PI_Q30);
    xa = longint'(a);
    yb = longint'(b);
    z = 0;
    while (xa < NORM_TOP && yb < NORM_TOP) begin
      xa = xa <<< 1;
      yb = yb <<< 1;
    end
    for (int i = 0; i < int'(STEPS) && i < 24; i++) begin
      dx = yb >>> i;
      dy = xa >>> i;
      if (yb >= 0) begin
        xa = xa + dx;
        yb = yb - dy;
        z = z + ARCTAN_STEP[i];
      end else begin
        xa = xa - dx;
        yb = yb + dy;
        z = z - ARCTAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    return longint'(z);
  endfunction

  // Q30 radians to degrees with FRAC_BITS fraction bits, magnitude rounded half up
  function automatic longint angle_in_degrees(input longint unsigned theta, input logic neg);
    longint unsigned num;
    longint m;
    num = ((theta * MILLIDEG_PER_RAD) << FRAC_BITS) + (64'd500 << 30);
    m = longint'(num / (64'd1000 << 30));
    return neg ? -m : m;
  endfunction

  // Work out both angles for one raw sample
  function automatic tilt_angles_t tilt_from_sample(input logic [IN_W-1:0] xw,
                                                    input logic [IN_W-1:0] yw,
                                                    input logic [IN_W-1:0] zw);
    longint sx;
    longint sy;
    longint sz;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned az;
    longint unsigned theta;
    longint unsigned radius;
    longint roll;
    longint pitch;
    tilt_angles_t res;
    sx = $signed(xw);
    sy = $signed(yw);
    sz = $signed(zw);
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    // roll: mirror into the left half-plane when z is negative, sign from -y
    theta = quadrant_angle(az, ay);
    if (sz < 0) theta = longint'(PI_Q30) - theta;
    roll = angle_in_degrees(theta, sy >= 0);
    // pitch: against the magnitude of the y-z vector, in Q16
    radius = root_floor((ay * ay + az * az) << 32);
    theta = quadrant_angle(radius, ax << 16);
    pitch = angle_in_degrees(theta, sx < 0);
    res.roll  = roll[ROLL_W-1:0];
    res.pitch = pitch[PITCH_W-1:0];
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what);
    $display("tilt check @%0t: %s", $time, what);
    fails_seen++;
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    tilt_angles_t want;
    tilt_angles_t got;
    longint half_turn;
    longint quarter_turn;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = tilt_from_sample(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
        half_turn = angle_in_degrees(longint'(PI_Q30), 1'b1);
        quarter_turn = angle_in_degrees(longint'(HALF_PI_Q30), 1'b0);
        if (want.roll == half_turn[ROLL_W-1:0] ||
            want.pitch == quarter_turn[PITCH_W-1:0] ||
            want.pitch == PITCH_W'(-quarter_turn))
          edge_cases_seen++;
        expected_angles.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.roll  = out_tdata[ROLL_W-1:0];
        got.pitch = out_tdata[ROLL_W+PITCH_W-1:ROLL_W];
        if (expected_angles.size() == 0) begin
          flag_mismatch($sformatf("result roll=%0d pitch=%0d with no request outstanding",
                                  $signed(got.roll), $signed(got.pitch)));
        end else begin
          want = expected_angles.pop_front();
          results_seen++;
          if (got.roll !== want.roll)
            flag_mismatch($sformatf("roll %0d, expected %0d",
                                    $signed(got.roll), $signed(want.roll)));
          if (got.pitch !== want.pitch)
            flag_mismatch($sformatf("pitch %0d, expected %0d",
                                    $signed(got.pitch), $signed(want.pitch)));
        end
      end
    end
  end

endmodule

>>> bench/accel_tilt_angles_tb.sv
`timescale 1ns / 100ps
// Top of the accel_tilt_angles bench: clock, reset, sample stimulus and result back-pressure.
// Depends on atp_pkg, the accel_tilt_angles RTL and tilt_angle_checker.
module accel_tilt_angles_tb;

  import atp_pkg::*;

  localparam int unsigned RANDOM_SAMPLES = 650;
  localparam int unsigned IDLE_PCT       = 13;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_NS    = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int  mismatches;
  int  pending;
  int  compared;
  int  extremes;
  int  samples_sent = 0;
  bit  calm = 1'b0;
  bit  want_hold = 1'b0;

  always #1 clk = ~clk;

  accel_tilt_angles i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tilt_angle_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared),
    .extremes   (extremes)
  );

  // Offer one sample, idling at random first, and hold it until accepted
  task automatic send_sample(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                             input logic [IN_W-1:0] z);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Signed value around a centre, truncated to a raw word
  function automatic logic [IN_W-1:0] around(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    return IN_W'(v);
  endfunction

  // Result side: random stalls, a calm stretch, and one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_served;
    hold_left = 0;
    hold_served = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (want_hold && !hold_served) begin
        hold_served = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned kind;
    int unsigned axis;
    int          g;
    logic [IN_W-1:0] w [3];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zeros, full-scale words, zero y with either sign of z, pure x, pure y, mixed words
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h8000);
    send_sample(16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'h0000, 16'h0000, 16'h4000);
    send_sample(16'h0000, 16'h0000, 16'h0001);
    send_sample(16'h0000, 16'h8000, 16'h0000);
    send_sample(16'h0000, 16'h7FFF, 16'h0000);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 16'h0001, 16'h0001);
    send_sample(16'h1234, 16'h0001, 16'h8000);
    send_sample(16'hEDCC, 16'hFFFF, 16'h8000);
    send_sample(16'h7FFF, 16'h0001, 16'h0000);
    send_sample(16'h8000, 16'h0000, 16'hC000);
    send_sample(16'h0000, 16'hC000, 16'h4000);
    send_sample(16'hAAAA, 16'h5555, 16'hA5A5);
    send_sample(16'h5555, 16'hAAAA, 16'h5A5A);

    // Random: full-range words, near-zero vectors, gravity on one axis, zero axes
    for (int n = 0; n < int'(RANDOM_SAMPLES); n++) begin
      calm = (n >= 200 && n < 330);
      if (n == 450) want_hold = 1'b1;
      kind = $urandom_range(9);
      if (kind <= 3) begin
        foreach (w[k]) w[k] = IN_W'($urandom);
      end else if (kind <= 5) begin
        foreach (w[k]) w[k] = around(0, 16);
      end else if (kind <= 8) begin
        axis = $urandom_range(2);
        g = ($urandom_range(1) != 0) ? 16384 : -16384;
        foreach (w[k]) w[k] = (k == axis) ? around(g, 2000) : around(0, 3000);
      end else begin
        foreach (w[k]) w[k] = ($urandom_range(1) != 0) ? IN_W'($urandom) : '0;
      end
      send_sample(w[0], w[1], w[2]);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    // Drain, then allow for anything still in flight
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples and compared %0d results", samples_sent, compared);
    $display("Half-turn roll or quarter-turn pitch expected on %0d samples", extremes);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(WATCHDOG_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
src/atp_pkg.sv
src/atp_sqrt.sv
src/atp_atan.sv
src/atp_deg.sv
src/accel_tilt_angles.sv
bench/tilt_angle_checker.sv
bench/accel_tilt_angles_tb.sv
